/* sv/cdd_pkg.sv */
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int YEAR_W = 16;

  localparam logic [2:0] MODE_YEARS   = 3'd0;
  localparam logic [2:0] MODE_MONTHS  = 3'd1;
  localparam logic [2:0] MODE_DAYS    = 3'd2;
  localparam logic [2:0] MODE_HOURS   = 3'd3;
  localparam logic [2:0] MODE_MINUTES = 3'd4;

  typedef enum logic [2:0] {
    K_YEARS   = 3'd0,
    K_MONTHS  = 3'd1,
    K_DAYS    = 3'd2,
    K_HOURS   = 3'd3,
    K_MINUTES = 3'd4,
    K_ZERO    = 3'd5
  } kind_t;

  typedef struct packed {
    logic [YEAR_W-1:0] y;
    logic [3:0]        m;
    logic [4:0]        d;
    logic [4:0]        h;
    logic [5:0]        mi;
  } stamp_t;

  typedef struct packed {
    kind_t  kind;
    stamp_t s;
    stamp_t e;
  } item_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [4:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [8:0] MONTH_START [13] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [3:0] MONTH_DEC   = 4'd12;
  localparam logic [4:0] FEB_LEAP    = 5'd29;
  localparam logic [4:0] FEB_PLAIN   = 5'd28;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [5:0] MINUTE_MAX  = 6'd59;
  localparam int         DAY_HOURS   = 24;
  localparam int         HOUR_MINS   = 60;
  localparam int         YEAR_MONTHS = 12;
  localparam int         YEAR_DAYS   = 365;
  localparam int         CENTURY     = 100;
  localparam int         QUAD_CENT   = 400;
  localparam int         JUMP_YEAR   = 2018;
  localparam int         JUMP_DAYS   = 737060;

  localparam logic [31:0] SAT_VAL  = 32'hFFFF_FFFF;
  localparam logic [31:0] HOUR_LIM = SAT_VAL / 32'd24;
  localparam logic [31:0] MIN_LIM  = SAT_VAL / 32'd1440;

  // Division by 100 through a scaled reciprocal, exact for DIV_XW-bit operands.
  localparam int DIV_XW = YEAR_W + 1;
  localparam int DIV_K  = DIV_XW + 7;
  localparam int DIV_MW = DIV_K - 6;
  localparam int DIV_QW = DIV_XW - 6;
  localparam logic [DIV_MW-1:0] DIV_M =
    DIV_MW'(((64'd1 << DIV_K) + 64'd99) / 64'd100);
  localparam int DIV_STEPS = 6;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int PART_W = YEAR_W;
  localparam int SER_W  = YEAR_W + 9;
  localparam int TOT_W  = (SER_W > 33) ? SER_W : 33;
  localparam int MON_W  = (YEAR_W + 5 > 33) ? YEAR_W + 5 : 33;

endpackage

/* sv/calendar_date_difference.sv */
`timescale 1ns / 1ps

// Elapsed time between two Gregorian timestamps in years, months, days,
// hours or minutes, chosen by in_mode.
// Input side: a transfer happens at a clock edge with push high and full low.
// The item is clamped and written into a two-entry queue.
// Result side: while empty is low the oldest result is on out_difference;
// a transfer happens at an edge with pop high and empty low.
// The back end works on one item at a time: it takes the item from the
// queue, forms six quotients on the shared divide-by-100 unit (three for
// each year), then works out day numbers, compares and scaling before the
// result lands in the output register. It takes no new item from the queue
// until the last result has gone into the output register.
// While a result waits to be popped, new items are still accepted into the
// queue; once the queue is full and the output stalls, full stays high.
// Synchronous reset empties the queue and the output register.
module calendar_date_difference (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic [4:0]  in_start_hour,
  input  logic [5:0]  in_start_minute,
  input  logic [15:0] in_end_year,
  input  logic [3:0]  in_end_month,
  input  logic [4:0]  in_end_day,
  input  logic [4:0]  in_end_hour,
  input  logic [5:0]  in_end_minute,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_difference
);

  cdd_pkg::item_t front_item;
  cdd_pkg::item_t q_data;
  logic           q_empty;
  logic           q_pop;

  cdd_front u_front (
    .in_mode         (in_mode),
    .in_start_year   (in_start_year),
    .in_start_month  (in_start_month),
    .in_start_day    (in_start_day),
    .in_start_hour   (in_start_hour),
    .in_start_minute (in_start_minute),
    .in_end_year     (in_end_year),
    .in_end_month    (in_end_month),
    .in_end_day      (in_end_day),
    .in_end_hour     (in_end_hour),
    .in_end_minute   (in_end_minute),
    .item            (front_item)
  );

  cdd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  cdd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_difference (out_difference)
  );

endmodule

/* sv/cdd_front.sv */
`timescale 1ns / 1ps

module cdd_front (
  input  logic [2:0]     in_mode,
  input  logic [15:0]    in_start_year,
  input  logic [3:0]     in_start_month,
  input  logic [4:0]     in_start_day,
  input  logic [4:0]     in_start_hour,
  input  logic [5:0]     in_start_minute,
  input  logic [15:0]    in_end_year,
  input  logic [3:0]     in_end_month,
  input  logic [4:0]     in_end_day,
  input  logic [4:0]     in_end_hour,
  input  logic [5:0]     in_end_minute,
  output cdd_pkg::item_t item
);

  localparam int YW = cdd_pkg::YEAR_W;

  // February is held to 29 days here; the back end trims it in plain years.
  function automatic cdd_pkg::stamp_t clamp_stamp(
    input logic [15:0] y,
    input logic [3:0]  m,
    input logic [4:0]  d,
    input logic [4:0]  h,
    input logic [5:0]  mi
  );
    cdd_pkg::stamp_t st;
    logic [4:0]      lim;
    st.y = YW'(y);
    if (m == 4'd0) begin
      st.m = 4'd1;
    end else if (m > cdd_pkg::MONTH_DEC) begin
      st.m = cdd_pkg::MONTH_DEC;
    end else begin
      st.m = m;
    end
    lim = (st.m == cdd_pkg::MONTH_FEB) ? cdd_pkg::FEB_LEAP : cdd_pkg::MONTH_LEN[st.m];
    if (d == 5'd0) begin
      st.d = 5'd1;
    end else if (d > lim) begin
      st.d = lim;
    end else begin
      st.d = d;
    end
    st.h  = (h > cdd_pkg::HOUR_MAX) ? cdd_pkg::HOUR_MAX : h;
    st.mi = (mi > cdd_pkg::MINUTE_MAX) ? cdd_pkg::MINUTE_MAX : mi;
    return st;
  endfunction

  always_comb begin
    case (in_mode)
      cdd_pkg::MODE_YEARS:   item.kind = cdd_pkg::K_YEARS;
      cdd_pkg::MODE_MONTHS:  item.kind = cdd_pkg::K_MONTHS;
      cdd_pkg::MODE_DAYS:    item.kind = cdd_pkg::K_DAYS;
      cdd_pkg::MODE_HOURS:   item.kind = cdd_pkg::K_HOURS;
      cdd_pkg::MODE_MINUTES: item.kind = cdd_pkg::K_MINUTES;
      default:               item.kind = cdd_pkg::K_ZERO;
    endcase
    item.s = clamp_stamp(in_start_year, in_start_month, in_start_day,
                         in_start_hour, in_start_minute);
    item.e = clamp_stamp(in_end_year, in_end_month, in_end_day,
                         in_end_hour, in_end_minute);
  end

endmodule

/* sv/cdd_queue.sv */
`timescale 1ns / 1ps

module cdd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  cdd_pkg::item_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output cdd_pkg::item_t rd_data,
  output logic           empty
);

  localparam int PTR_W = (cdd_pkg::QUEUE_DEPTH > 1) ? $clog2(cdd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(cdd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(cdd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(cdd_pkg::QUEUE_DEPTH);

  cdd_pkg::item_t   mem_r [cdd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* sv/cdd_back.sv */
`timescale 1ns / 1ps

module cdd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  cdd_pkg::item_t q_data,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [31:0]    out_difference
);

  localparam int YW   = cdd_pkg::YEAR_W;
  localparam int XW   = cdd_pkg::DIV_XW;
  localparam int QW   = cdd_pkg::DIV_QW;
  localparam int MW   = cdd_pkg::DIV_MW;
  localparam int SW   = cdd_pkg::STEP_W;
  localparam int PW   = cdd_pkg::PART_W;
  localparam int SERW = cdd_pkg::SER_W;
  localparam int TW   = cdd_pkg::TOT_W;
  localparam int MONW = cdd_pkg::MON_W;

  localparam logic [SW-1:0] STEP_S_Y    = SW'(0);
  localparam logic [SW-1:0] STEP_S_CENT = SW'(1);
  localparam logic [SW-1:0] STEP_S_QUAD = SW'(2);
  localparam logic [SW-1:0] STEP_E_Y    = SW'(3);
  localparam logic [SW-1:0] STEP_E_CENT = SW'(4);
  localparam logic [SW-1:0] STEP_E_QUAD = SW'(5);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DIV    = 8'b0000_0010,
    ST_LEAP   = 8'b0000_0100,
    ST_SER    = 8'b0000_1000,
    ST_DAYS   = 8'b0001_0000,
    ST_HOURS  = 8'b0010_0000,
    ST_FINISH = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  cdd_pkg::item_t   item_r, item_nxt;
  logic [QW-1:0]    q_r [cdd_pkg::DIV_STEPS];
  logic [PW-1:0]    s_part_r, s_part_nxt, e_part_r, e_part_nxt;
  logic [SERW-1:0]  s_ser_r, s_ser_nxt, e_ser_r, e_ser_nxt;
  logic [31:0]      days_r, days_nxt;
  logic [31:0]      hrs_r, hrs_nxt;
  logic [YW-1:0]    yrs_r, yrs_nxt;
  logic             gt2_r, gt2_nxt, gt4_r, gt4_nxt, gt5_r, gt5_nxt;
  logic [31:0]      res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_diff_r, out_diff_nxt;

  logic [XW-1:0]    div_x;
  logic [XW+MW-1:0] div_prod;
  logic [QW-1:0]    div_q;
  logic [YW-1:0]    sel_y;

  assign empty          = !out_valid_r;
  assign out_difference = out_diff_r;
  assign q_pop          = (state_r == ST_IDLE) && !q_empty;

  // A year is a multiple of 400 exactly when it is a multiple of 100 and of 16.
  function automatic logic is_leap(input logic [YW-1:0] y, input logic [QW-1:0] q0);
    logic [XW-1:0] back;
    back = XW'(q0) * XW'(cdd_pkg::CENTURY);
    return (y[1:0] == 2'd0) && ((back != XW'(y)) || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] trim_day(input cdd_pkg::stamp_t st, input logic lp);
    if (st.m == cdd_pkg::MONTH_FEB && !lp && st.d > cdd_pkg::FEB_PLAIN) begin
      return cdd_pkg::FEB_PLAIN;
    end
    return st.d;
  endfunction

  // Leap days before the year, the month offset and the day within the month.
  function automatic logic [PW-1:0] part_of(
    input logic [YW-1:0] y,
    input logic [3:0]    m,
    input logic [4:0]    d,
    input logic          lp,
    input logic [QW-1:0] q_cent,
    input logic [QW-1:0] q_quad
  );
    logic [XW-1:0] quads;
    logic [PW-1:0] leaps;
    quads = (XW'(y) + XW'(3)) >> 2;
    leaps = PW'(quads) - PW'(q_cent) + PW'(q_quad);
    return leaps + PW'(cdd_pkg::MONTH_START[m]) + PW'(d - 5'd1)
           + PW'(lp && (m > cdd_pkg::MONTH_FEB));
  endfunction

  always_comb begin
    sel_y = (step_r < STEP_E_Y) ? item_r.s.y : item_r.e.y;
    if (step_r == STEP_S_CENT || step_r == STEP_E_CENT) begin
      div_x = XW'(sel_y) + XW'(cdd_pkg::CENTURY - 1);
    end else if (step_r == STEP_S_QUAD || step_r == STEP_E_QUAD) begin
      div_x = (XW'(sel_y) + XW'(cdd_pkg::QUAD_CENT - 1)) >> 2;
    end else begin
      div_x = XW'(sel_y);
    end
    div_prod = (XW+MW)'(div_x) * (XW+MW)'(cdd_pkg::DIV_M);
    div_q    = div_prod[cdd_pkg::DIV_K +: QW];
  end

  always_comb begin
    logic          s_lp, e_lp;
    logic [4:0]    s_d, e_d;
    logic [TW-1:0] tot;
    logic [MONW-1:0] mon;
    logic [YW-1:0] yrs_m1;
    logic [31:0]   hrs_m1;

    state_nxt     = state_r;
    step_nxt      = step_r;
    item_nxt      = item_r;
    s_part_nxt    = s_part_r;
    e_part_nxt    = e_part_r;
    s_ser_nxt     = s_ser_r;
    e_ser_nxt     = e_ser_r;
    days_nxt      = days_r;
    hrs_nxt       = hrs_r;
    yrs_nxt       = yrs_r;
    gt2_nxt       = gt2_r;
    gt4_nxt       = gt4_r;
    gt5_nxt       = gt5_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !pop;
    out_diff_nxt  = out_diff_r;

    s_lp   = is_leap(item_r.s.y, q_r[STEP_S_Y]);
    e_lp   = is_leap(item_r.e.y, q_r[STEP_E_Y]);
    s_d    = trim_day(item_r.s, s_lp);
    e_d    = trim_day(item_r.e, e_lp);
    tot    = '0;
    mon    = '0;
    yrs_m1 = (yrs_r > YW'(1)) ? yrs_r - YW'(1) : '0;
    hrs_m1 = (hrs_r > 32'd1) ? hrs_r - 32'd1 : 32'd0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          item_nxt  = q_data;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        step_nxt = step_r + SW'(1);
        if (step_r == STEP_E_QUAD) begin
          state_nxt = ST_LEAP;
        end
      end
      ST_LEAP: begin
        item_nxt.s.d = s_d;
        item_nxt.e.d = e_d;
        s_part_nxt = part_of(item_r.s.y, item_r.s.m, s_d, s_lp,
                             q_r[STEP_S_CENT], q_r[STEP_S_QUAD]);
        e_part_nxt = part_of(item_r.e.y, item_r.e.m, e_d, e_lp,
                             q_r[STEP_E_CENT], q_r[STEP_E_QUAD]);
        state_nxt  = ST_SER;
      end
      ST_SER: begin
        s_ser_nxt = SERW'(item_r.s.y) * SERW'(cdd_pkg::YEAR_DAYS) + SERW'(s_part_r);
        e_ser_nxt = SERW'(item_r.e.y) * SERW'(cdd_pkg::YEAR_DAYS) + SERW'(e_part_r);
        state_nxt = ST_SER == state_r ? ST_DAYS : state_r;
      end
      ST_DAYS: begin
        // The day number of the jump date equals the days it credits, so the
        // jumped count is simply the end's day number.
        if (item_r.s.y == '0 && item_r.e.y >= YW'(cdd_pkg::JUMP_YEAR)) begin
          tot = TW'(e_ser_r);
        end else if (e_ser_r > s_ser_r) begin
          tot = TW'(e_ser_r - s_ser_r);
        end
        days_nxt = (tot >= TW'(cdd_pkg::SAT_VAL)) ? cdd_pkg::SAT_VAL : tot[31:0];
        yrs_nxt  = (item_r.s.y >= item_r.e.y) ? '0 : item_r.e.y - item_r.s.y;
        gt2_nxt  = {item_r.s.y, item_r.s.m} > {item_r.e.y, item_r.e.m};
        gt4_nxt  = {item_r.s.y, item_r.s.m, item_r.s.d, item_r.s.h}
                 > {item_r.e.y, item_r.e.m, item_r.e.d, item_r.e.h};
        gt5_nxt  = item_r.s > item_r.e;
        state_nxt = ST_HOURS;
      end
      ST_HOURS: begin
        if (gt4_r) begin
          hrs_nxt = 32'd0;
        end else if (days_r >= cdd_pkg::HOUR_LIM) begin
          hrs_nxt = cdd_pkg::SAT_VAL;
        end else if (item_r.s.h > item_r.e.h) begin
          hrs_nxt = (days_r == 32'd0) ? 32'd0 :
                    (days_r - 32'd1) * 32'(cdd_pkg::DAY_HOURS) + 32'(item_r.e.h)
                    + 32'(cdd_pkg::DAY_HOURS) - 32'(item_r.s.h);
        end else begin
          hrs_nxt = days_r * 32'(cdd_pkg::DAY_HOURS) + 32'(item_r.e.h) - 32'(item_r.s.h);
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        case (item_r.kind)
          cdd_pkg::K_YEARS: res_nxt = 32'(yrs_r);
          cdd_pkg::K_MONTHS: begin
            if (item_r.e.m >= item_r.s.m) begin
              mon = MONW'(yrs_r) * MONW'(cdd_pkg::YEAR_MONTHS)
                  + MONW'(item_r.e.m) - MONW'(item_r.s.m);
            end else begin
              mon = MONW'(yrs_m1) * MONW'(cdd_pkg::YEAR_MONTHS) + MONW'(item_r.e.m)
                  + MONW'(cdd_pkg::YEAR_MONTHS) - MONW'(item_r.s.m);
            end
            if (gt2_r) begin
              res_nxt = 32'd0;
            end else if (mon >= MONW'(cdd_pkg::SAT_VAL)) begin
              res_nxt = cdd_pkg::SAT_VAL;
            end else begin
              res_nxt = mon[31:0];
            end
          end
          cdd_pkg::K_DAYS:  res_nxt = days_r;
          cdd_pkg::K_HOURS: res_nxt = hrs_r;
          cdd_pkg::K_MINUTES: begin
            if (gt5_r) begin
              res_nxt = 32'd0;
            end else if (days_r >= cdd_pkg::MIN_LIM) begin
              res_nxt = cdd_pkg::SAT_VAL;
            end else if (item_r.s.mi > item_r.e.mi) begin
              res_nxt = hrs_m1 * 32'(cdd_pkg::HOUR_MINS) + 32'(item_r.e.mi)
                      + 32'(cdd_pkg::HOUR_MINS) - 32'(item_r.s.mi);
            end else begin
              res_nxt = hrs_r * 32'(cdd_pkg::HOUR_MINS) + 32'(item_r.e.mi)
                      - 32'(item_r.s.mi);
            end
          end
          default: res_nxt = 32'd0;
        endcase
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt = 1'b1;
          out_diff_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    item_r     <= item_nxt;
    s_part_r   <= s_part_nxt;
    e_part_r   <= e_part_nxt;
    s_ser_r    <= s_ser_nxt;
    e_ser_r    <= e_ser_nxt;
    days_r     <= days_nxt;
    hrs_r      <= hrs_nxt;
    yrs_r      <= yrs_nxt;
    gt2_r      <= gt2_nxt;
    gt4_r      <= gt4_nxt;
    gt5_r      <= gt5_nxt;
    res_r      <= res_nxt;
    out_diff_r <= out_diff_nxt;
    if (state_r == ST_DIV) begin
      q_r[step_r] <= div_q;
    end
  end

endmodule
